FILE: design/pgtfl_pkg.sv
// Package for the page table block: command codes and the request record
// that travels along the row of page cells. No dependencies.
package pgtfl_pkg;

    localparam int DEF_PAGES      = 64;
    localparam int DEF_STAMP_BITS = 32;
    localparam int PAGE_W         = 8;
    localparam int FRAME_W        = 6;

    typedef enum logic [2:0] {
        MODE_LOOKUP     = 3'd0,
        MODE_UPDATE     = 3'd1,
        MODE_VICTIM     = 3'd2,
        MODE_REVERSE    = 3'd3,
        MODE_INVALIDATE = 3'd4
    } mode_t;

    // Request record plus the partial result built up as it passes each cell.
    typedef struct packed {
        logic               active;
        mode_t              mode;
        logic [PAGE_W-1:0]  page;
        logic               ev;
        logic               em;
        logic [FRAME_W-1:0] ef;
        logic [FRAME_W-1:0] qf;
        logic               status;
        logic               found;
        logic               ov;
        logic               om;
        logic [FRAME_W-1:0] ofr;
        logic [FRAME_W-1:0] opg;
        logic [FRAME_W-1:0] vf;
    } pgtfl_req_t;

endpackage

FILE: design/pgtfl_cell.sv
// One page cell: holds a single page entry and handles the passing request
// and registers it before handing it to the next cell. Depends on pgtfl_pkg.
module pgtfl_cell #(
    parameter int INDEX      = 0,
    parameter int STAMP_BITS = pgtfl_pkg::DEF_STAMP_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   policy,
    input  pgtfl_pkg::pgtfl_req_t  req_in,
    input  logic [STAMP_BITS-1:0]  acnt_in,
    input  logic [STAMP_BITS-1:0]  icnt_in,
    input  logic [STAMP_BITS-1:0]  best_in,
    output pgtfl_pkg::pgtfl_req_t  req_out,
    output logic [STAMP_BITS-1:0]  acnt_out,
    output logic [STAMP_BITS-1:0]  icnt_out,
    output logic [STAMP_BITS-1:0]  best_out
);
    import pgtfl_pkg::*;

    localparam logic [PAGE_W-1:0]  MY_PAGE  = PAGE_W'(INDEX);
    localparam logic [FRAME_W-1:0] MY_FRAME = FRAME_W'(INDEX % 64);

    logic                  valid_reg, valid_next;
    logic                  mod_reg, mod_next;
    logic [FRAME_W-1:0]    frame_reg, frame_next;
    logic [STAMP_BITS-1:0] astamp_reg, astamp_next;
    logic [STAMP_BITS-1:0] istamp_reg, istamp_next;
    pgtfl_req_t            req_reg, req_next;
    logic [STAMP_BITS-1:0] acnt_reg, icnt_reg, best_reg, best_next;
    logic [STAMP_BITS-1:0] sel_stamp;
    logic                  hit;

    assign hit       = (req_in.page == MY_PAGE);
    assign sel_stamp = policy ? astamp_reg : istamp_reg;

    always_comb
    begin
        valid_next  = valid_reg;
        mod_next    = mod_reg;
        frame_next  = frame_reg;
        astamp_next = astamp_reg;
        istamp_next = istamp_reg;
        req_next    = req_in;
        best_next   = best_in;
        if (req_in.active)
        begin
            case (req_in.mode)
                MODE_LOOKUP:
                begin
                    if (hit)
                    begin
                        req_next.ov  = valid_reg;
                        req_next.om  = mod_reg;
                        req_next.ofr = frame_reg;
                        if (policy)
                        begin
                            astamp_next = acnt_in;
                        end
                    end
                end
                MODE_UPDATE:
                begin
                    if (hit)
                    begin
                        valid_next  = req_in.ev;
                        mod_next    = req_in.em;
                        frame_next  = req_in.ef;
                        astamp_next = acnt_in;
                        istamp_next = icnt_in;
                    end
                end
                MODE_VICTIM:
                begin
                    if (valid_reg && (!req_in.found || sel_stamp < best_in))
                    begin
                        req_next.found = 1'b1;
                        req_next.vf    = frame_reg;
                        best_next      = sel_stamp;
                    end
                end
                MODE_REVERSE:
                begin
                    if (valid_reg && frame_reg == req_in.qf)
                    begin
                        req_next.ov     = 1'b1;
                        req_next.om     = mod_reg;
                        req_next.ofr    = frame_reg;
                        req_next.opg    = MY_FRAME;
                        req_next.status = 1'b0;
                    end
                end
                MODE_INVALIDATE:
                begin
                    valid_next  = 1'b0;
                    frame_next  = MY_FRAME;
                    astamp_next = '0;
                    istamp_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            mod_reg    <= 1'b0;
            frame_reg  <= MY_FRAME;
            astamp_reg <= '0;
            istamp_reg <= '0;
            req_reg    <= '0;
        end
        else
        begin
            valid_reg  <= valid_next;
            mod_reg    <= mod_next;
            frame_reg  <= frame_next;
            astamp_reg <= astamp_next;
            istamp_reg <= istamp_next;
            req_reg    <= req_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acnt_reg <= acnt_in;
        icnt_reg <= icnt_in;
        best_reg <= best_next;
    end

    assign req_out  = req_reg;
    assign acnt_out = acnt_reg;
    assign icnt_out = icnt_reg;
    assign best_out = best_reg;

endmodule

FILE: design/page_table_fifo_lru_victim_core.sv
// Top level of the page table with FIFO or LRU victim selection: launch
// register, stamp counters, the row of page cells and the result register.
// Depends on pgtfl_pkg and pgtfl_cell.
//
//   Channel   Handshake               Contents
//   request   req_valid / req_stall   mode, page_number, entry_*, query_frame
//   result    rsp_valid / rsp_stall   status, out_*, victim_frame
//   config    policy_we               policy_wdata (replacement policy)
//
// Every request walks the whole row of PAGES cells, one cell per cycle, from
// the launch register to the result register; the length of the cell row
// sets the time to a result for every command alike.
// One request is in flight at a time: req_stall stays high from acceptance
// until the result has been taken on the result channel, so the block takes
// no new request before it is through with the last one.
// Reset clears all valid and modified bits, sets each frame to its page index,
// clears both stamp counters and all stamps, and selects the FIFO policy.
// A stalled result holds its value until rsp_stall drops.
module page_table_fifo_lru_victim_core #(
    parameter int PAGES      = pgtfl_pkg::DEF_PAGES,
    parameter int STAMP_BITS = pgtfl_pkg::DEF_STAMP_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         policy_we,
    input  logic                         policy_wdata,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  logic [2:0]                   mode,
    input  logic [pgtfl_pkg::PAGE_W-1:0] page_number,
    input  logic                         entry_valid,
    input  logic                         entry_modified,
    input  logic [pgtfl_pkg::FRAME_W-1:0] entry_frame,
    input  logic [pgtfl_pkg::FRAME_W-1:0] query_frame,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output logic                         status,
    output logic                         out_valid,
    output logic                         out_modified,
    output logic [pgtfl_pkg::FRAME_W-1:0] out_frame,
    output logic [pgtfl_pkg::FRAME_W-1:0] out_page,
    output logic [pgtfl_pkg::FRAME_W-1:0] victim_frame
);
    import pgtfl_pkg::*;

    logic                  policy_reg;
    logic                  busy_reg;
    logic                  rsp_valid_reg;
    logic [STAMP_BITS-1:0] acnt_reg, acnt_next;
    logic [STAMP_BITS-1:0] icnt_reg, icnt_next;
    logic [STAMP_BITS-1:0] launch_acnt_reg, launch_icnt_reg;
    pgtfl_req_t            launch_reg, launch_next;
    pgtfl_req_t            result_reg;
    mode_t                 cmd;
    logic                  accept, in_range;

    pgtfl_req_t            chain_req  [0:PAGES];
    logic [STAMP_BITS-1:0] chain_acnt [0:PAGES];
    logic [STAMP_BITS-1:0] chain_icnt [0:PAGES];
    logic [STAMP_BITS-1:0] chain_best [0:PAGES];

    assign cmd      = mode_t'(mode);
    assign accept   = req_valid && !req_stall;
    assign in_range = ({1'b0, page_number} < (PAGE_W + 1)'(PAGES));
    assign req_stall = busy_reg;

    // Build the launched request with its starting status. Lookup and update
    // fail only when the page is out of range; reverse lookup fails until a
    // cell reports a match; unknown commands always fail.
    always_comb
    begin
        launch_next        = '0;
        launch_next.active = accept;
        launch_next.mode   = cmd;
        launch_next.page   = page_number;
        launch_next.ev     = entry_valid;
        launch_next.em     = entry_modified;
        launch_next.ef     = entry_frame;
        launch_next.qf     = query_frame;
        acnt_next          = acnt_reg;
        icnt_next          = icnt_reg;
        case (cmd)
            MODE_LOOKUP:
            begin
                launch_next.status = !in_range;
                if (accept && in_range && policy_reg)
                begin
                    acnt_next = acnt_reg + 1'b1;
                end
            end
            MODE_UPDATE:
            begin
                launch_next.status = !in_range;
                if (accept && in_range)
                begin
                    acnt_next = acnt_reg + 1'b1;
                    icnt_next = icnt_reg + 1'b1;
                end
            end
            MODE_VICTIM:
            begin
                launch_next.status = 1'b0;
            end
            MODE_REVERSE:
            begin
                launch_next.status = 1'b1;
            end
            MODE_INVALIDATE:
            begin
                launch_next.status = 1'b0;
                if (accept)
                begin
                    acnt_next = '0;
                    icnt_next = '0;
                end
            end
            default:
            begin
                launch_next.status = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg    <= 1'b0;
            busy_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            acnt_reg      <= '0;
            icnt_reg      <= '0;
            launch_reg    <= '0;
        end
        else
        begin
            if (policy_we)
            begin
                policy_reg <= policy_wdata;
            end
            acnt_reg   <= acnt_next;
            icnt_reg   <= icnt_next;
            launch_reg <= launch_next;
            if (chain_req[PAGES].active)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // The launch stamps are the counter values before this request's step.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            launch_acnt_reg <= acnt_reg;
            launch_icnt_reg <= icnt_reg;
        end
        if (chain_req[PAGES].active)
        begin
            result_reg <= chain_req[PAGES];
        end
    end

    assign chain_req[0]  = launch_reg;
    assign chain_acnt[0] = launch_acnt_reg;
    assign chain_icnt[0] = launch_icnt_reg;
    assign chain_best[0] = '0;

    for (genvar g = 0; g < PAGES; g++)
    begin : g_cell
        pgtfl_cell #(
            .INDEX      (g),
            .STAMP_BITS (STAMP_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .policy   (policy_reg),
            .req_in   (chain_req[g]),
            .acnt_in  (chain_acnt[g]),
            .icnt_in  (chain_icnt[g]),
            .best_in  (chain_best[g]),
            .req_out  (chain_req[g+1]),
            .acnt_out (chain_acnt[g+1]),
            .icnt_out (chain_icnt[g+1]),
            .best_out (chain_best[g+1])
        );
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = result_reg.status;
    assign out_valid    = result_reg.ov;
    assign out_modified = result_reg.om;
    assign out_frame    = result_reg.ofr;
    assign out_page     = result_reg.opg;
    assign victim_frame = result_reg.vf;

endmodule

FILE: sim/pgtfl_checker.sv
// Checker for the page table block: watches the request, result and policy
// ports, predicts each result with its own table copy and compares.
// Depends on pgtfl_pkg.
module pgtfl_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       policy_we,
    input  logic       policy_wdata,
    input  logic       req_valid,
    input  logic       req_stall,
    input  logic [2:0] mode,
    input  logic [7:0] page_number,
    input  logic       entry_valid,
    input  logic       entry_modified,
    input  logic [5:0] entry_frame,
    input  logic [5:0] query_frame,
    input  logic       rsp_valid,
    input  logic       rsp_stall,
    input  logic       status,
    input  logic       out_valid,
    input  logic       out_modified,
    input  logic [5:0] out_frame,
    input  logic [5:0] out_page,
    input  logic [5:0] victim_frame,
    output int         fail_count,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import pgtfl_pkg::*;

    localparam int NPAGES = 64;

    typedef struct packed {
        logic       status;
        logic       ov;
        logic       om;
        logic [5:0] ofr;
        logic [5:0] opg;
        logic [5:0] vf;
    } page_result_t;

    logic        lru_policy;
    logic        pt_valid [NPAGES];
    logic        pt_mod [NPAGES];
    logic [5:0]  pt_frame [NPAGES];
    logic [31:0] pt_access [NPAGES];
    logic [31:0] pt_insert [NPAGES];
    logic [31:0] access_ctr;
    logic [31:0] insert_ctr;
    page_result_t expected_results [$];

    assign pending = expected_results.size();

    function automatic void clear_table();
        access_ctr = '0;
        insert_ctr = '0;
        for (int i = 0; i < NPAGES; i++)
        begin
            pt_valid[i] = 1'b0;
            pt_frame[i] = 6'(i);
            pt_access[i] = '0;
            pt_insert[i] = '0;
        end
    endfunction

    function automatic page_result_t predict_page_op(logic [2:0] op, logic [7:0] pg,
                                                     logic ev, logic em,
                                                     logic [5:0] ef, logic [5:0] qf);
        page_result_t r;
        logic         found;
        logic [31:0]  best;
        logic [31:0]  s;
        r = '0;
        r.status = 1'b1;
        case (op)
            MODE_LOOKUP:
                if (pg < NPAGES)
                begin
                    r.ov = pt_valid[pg];
                    r.om = pt_mod[pg];
                    r.ofr = pt_frame[pg];
                    if (lru_policy)
                    begin
                        pt_access[pg] = access_ctr;
                        access_ctr++;
                    end
                    r.status = 1'b0;
                end
            MODE_UPDATE:
                if (pg < NPAGES)
                begin
                    pt_valid[pg] = ev;
                    pt_mod[pg] = em;
                    pt_frame[pg] = ef;
                    pt_access[pg] = access_ctr;
                    pt_insert[pg] = insert_ctr;
                    access_ctr++;
                    insert_ctr++;
                    r.status = 1'b0;
                end
            MODE_VICTIM:
            begin
                found = 1'b0;
                best = '0;
                for (int i = 0; i < NPAGES; i++)
                begin
                    s = lru_policy ? pt_access[i] : pt_insert[i];
                    if (pt_valid[i] && (!found || s < best))
                    begin
                        found = 1'b1;
                        best = s;
                        r.vf = pt_frame[i];
                    end
                end
                r.status = 1'b0;
            end
            MODE_REVERSE:
                for (int i = 0; i < NPAGES; i++)
                    if (pt_valid[i] && pt_frame[i] == qf)
                    begin
                        r.ov = 1'b1;
                        r.om = pt_mod[i];
                        r.ofr = pt_frame[i];
                        r.opg = 6'(i);
                        r.status = 1'b0;
                    end
            MODE_INVALIDATE:
            begin
                clear_table();
                r.status = 1'b0;
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        page_result_t e;
        if (!rst_n)
        begin
            lru_policy <= 1'b0;
            for (int i = 0; i < NPAGES; i++)
                pt_mod[i] = 1'b0;
            clear_table();
            expected_results.delete();
            fail_count <= 0;
        end
        else
        begin
            if (policy_we)
                lru_policy <= policy_wdata;
            if (req_valid && !req_stall)
                expected_results.push_back(predict_page_op(mode, page_number, entry_valid,
                    entry_modified, entry_frame, query_frame));
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request waiting");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if ({status, out_valid, out_modified, out_frame, out_page, victim_frame}
                        != e)
                    begin
                        fail_count <= fail_count + 1;
                        if (status !== e.status)
                            $error("status expected %0d got %0d", e.status, status);
                        if (out_valid !== e.ov)
                            $error("out_valid expected %0d got %0d", e.ov, out_valid);
                        if (out_modified !== e.om)
                            $error("out_modified expected %0d got %0d", e.om, out_modified);
                        if (out_frame !== e.ofr)
                            $error("out_frame expected %0d got %0d", e.ofr, out_frame);
                        if (out_page !== e.opg)
                            $error("out_page expected %0d got %0d", e.opg, out_page);
                        if (victim_frame !== e.vf)
                            $error("victim_frame expected %0d got %0d", e.vf, victim_frame);
                    end
                end
            end
        end
    end
endmodule

FILE: sim/tb_page_table_fifo_lru_victim_core.sv
// Testbench top for the page table block: clock, reset, request stimulus,
// result stalls and the verdict. Depends on pgtfl_pkg, pgtfl_checker and the core.
module tb_page_table_fifo_lru_victim_core;
    timeunit 1ns;
    timeprecision 1ps;
    import pgtfl_pkg::*;

    // A request walks 64 cells plus launch and result registers.
    localparam int LATENCY = 66;
    localparam int CYCLE_LIMIT = 1500000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       policy_we = 1'b0;
    logic       policy_wdata = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_stall;
    logic [2:0] mode = '0;
    logic [7:0] page_number = '0;
    logic       entry_valid = 1'b0;
    logic       entry_modified = 1'b0;
    logic [5:0] entry_frame = '0;
    logic [5:0] query_frame = '0;
    logic       rsp_valid;
    logic       rsp_stall = 1'b0;
    logic       status;
    logic       out_valid;
    logic       out_modified;
    logic [5:0] out_frame;
    logic [5:0] out_page;
    logic [5:0] victim_frame;
    int         fail_count;
    int         pending;
    int         cycle_count = 0;
    bit         hold_off = 1'b0;

    // The clock: 4 ns high, 4 ns low.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    page_table_fifo_lru_victim_core dut (.*);

    pgtfl_checker checker_i (.*);

    // Watchdog: any hang ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Random idle length: usually short, now and then a long gap.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 120);
    endfunction

    // The result side stalls at random, and during the long hold-off it
    // stalls continuously so the single in-flight request backs up the input.
    always @(posedge clk)
    begin
        if (hold_off)
            rsp_stall <= 1'b1;
        else
            rsp_stall <= ($urandom_range(0, 99) < 30) && ($urandom_range(0, 3) != 0);
    end

    // Offers one request and holds it steady until the core accepts it.
    // The valid stays high after acceptance; it drops only before an idle gap,
    // so back-to-back offers never drive it twice in one time step.
    task automatic send_request(logic [2:0] op, logic [7:0] pg, logic ev, logic em,
                                logic [5:0] ef, logic [5:0] qf);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        mode <= op;
        page_number <= pg;
        entry_valid <= ev;
        entry_modified <= em;
        entry_frame <= ef;
        query_frame <= qf;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
    endtask

    // Waits for every outstanding request to drain, then writes the policy.
    task automatic write_policy(logic lru);
        req_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        policy_we <= 1'b1;
        policy_wdata <= lru;
        @(posedge clk);
        policy_we <= 1'b0;
    endtask

    // Random well-formed traffic: updates most often, pages often from a small set so
    // lookups, reverse lookups and victims hit real entries; a few junk items.
    task automatic random_requests(int count);
        int r;
        logic [2:0] op;
        logic [7:0] pg;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
                op = MODE_UPDATE;
            else if (r < 60)
                op = MODE_LOOKUP;
            else if (r < 75)
                op = MODE_VICTIM;
            else if (r < 90)
                op = MODE_REVERSE;
            else if (r < 93)
                op = MODE_INVALIDATE;
            else
                op = 3'($urandom_range(5, 7));
            if ($urandom_range(0, 9) == 0)
                pg = 8'($urandom_range(0, 255));
            else if ($urandom_range(0, 1) == 0)
                pg = 8'($urandom_range(0, 7));
            else
                pg = 8'($urandom_range(0, 63));
            send_request(op, pg, $urandom_range(0, 5) != 0, 1'($urandom),
                         ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 7))
                                                     : 6'($urandom),
                         ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 7))
                                                     : 6'($urandom));
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the FIFO policy: empty victim, extremes, misses.
        send_request(MODE_VICTIM, 8'd0, 1'b0, 1'b0, 6'd0, 6'd0);
        send_request(MODE_LOOKUP, 8'd63, 1'b0, 1'b0, 6'd0, 6'd0);
        send_request(MODE_LOOKUP, 8'd64, 1'b0, 1'b0, 6'd0, 6'd0);
        send_request(MODE_LOOKUP, 8'd255, 1'b0, 1'b0, 6'd0, 6'd0);
        send_request(MODE_UPDATE, 8'd255, 1'b1, 1'b1, 6'd63, 6'd0);
        send_request(MODE_UPDATE, 8'd0, 1'b1, 1'b1, 6'd63, 6'd0);
        send_request(MODE_UPDATE, 8'd63, 1'b1, 1'b0, 6'd63, 6'd0);
        send_request(MODE_UPDATE, 8'd5, 1'b1, 1'b1, 6'd0, 6'd0);
        send_request(MODE_UPDATE, 8'd9, 1'b0, 1'b1, 6'd21, 6'd0);
        send_request(MODE_REVERSE, 8'd0, 1'b0, 1'b0, 6'd0, 6'd63);
        send_request(MODE_REVERSE, 8'd0, 1'b0, 1'b0, 6'd0, 6'd21);
        send_request(MODE_REVERSE, 8'd255, 1'b1, 1'b1, 6'd63, 6'd0);
        send_request(MODE_LOOKUP, 8'd0, 1'b0, 1'b0, 6'd0, 6'd0);
        send_request(MODE_VICTIM, 8'd0, 1'b0, 1'b0, 6'd0, 6'd0);
        send_request(3'd5, 8'd1, 1'b1, 1'b1, 6'd1, 6'd1);
        send_request(3'd7, 8'd255, 1'b1, 1'b1, 6'd63, 6'd63);
        send_request(MODE_INVALIDATE, 8'd0, 1'b0, 1'b0, 6'd0, 6'd0);
        // Modified bits survive invalidate all.
        send_request(MODE_LOOKUP, 8'd5, 1'b0, 1'b0, 6'd0, 6'd0);
        send_request(MODE_VICTIM, 8'd0, 1'b0, 1'b0, 6'd0, 6'd0);

        // LRU policy: lookups restamp, so the victim changes.
        write_policy(1'b1);
        send_request(MODE_UPDATE, 8'd3, 1'b1, 1'b0, 6'd30, 6'd0);
        send_request(MODE_UPDATE, 8'd4, 1'b1, 1'b0, 6'd40, 6'd0);
        send_request(MODE_LOOKUP, 8'd3, 1'b0, 1'b0, 6'd0, 6'd0);
        send_request(MODE_VICTIM, 8'd0, 1'b0, 1'b0, 6'd0, 6'd0);

        // Receiver holds off for a long stretch while requests keep coming.
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            random_requests(8);
        join

        random_requests(380);
        write_policy(1'b0);
        random_requests(380);
        write_policy(1'b1);
        random_requests(370);

        req_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
